// ----- rtl/wrsa_pkg.sv -----
// shared constants for the weighted random select with aging block
package wrsa_pkg;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int RND_W      = 32;
	localparam int LOAD_W     = 16;
	localparam int EXT_IDX_W  = 4;
	localparam int CFG_W      = 5;

	localparam logic REG_ACTIVE_COUNT = 1'b0;

	localparam logic MODE_SELECT = 1'b0;
	localparam logic MODE_LOAD   = 1'b1;

endpackage

// ----- rtl/wrsa_ram.sv -----
// generic single write port ram with registered read
module wrsa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/weighted_random_select_aging.sv -----
// Weighted random select with aging. A load item (mode 1) writes one entry weight.
// A select item (mode 0) picks one of the first active_count entries:
// entry 0 when only one is active, random_word mod active_count when all weights are
// zero, else the first entry whose running weight total exceeds random_word mod the
// weight sum; afterwards every active weight ages by one (saturating) and the winner's
// weight is cleared. A select is one pass over the weight ram to add the weights, a
// 32-step restoring divider that yields the remainder, one read-modify-write pass that
// finds the winner and ages the weights, then a state that presents the result item once
// the previous one is no longer stalled; in_stall is high until then. The single ram port
// pair and the one-bit-a-cycle divider set the length of a select. The weight ram needs
// no clearing pass; per-entry valid bits make unwritten weights read as zero.
module weighted_random_select_aging
	import wrsa_pkg::*;
#(
	parameter int NUM_ENTRIES = 16,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  mode,
	input  logic [RND_W-1:0]      random_word,
	input  logic [EXT_IDX_W-1:0]  load_index,
	input  logic [LOAD_W-1:0]     load_weight,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [EXT_IDX_W-1:0]  chosen_index,
	output logic                  was_uniform,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int IDX_W = $clog2(NUM_ENTRIES);
	localparam int CNT_W = $clog2(NUM_ENTRIES + 1);
	localparam int SUM_W = WEIGHT_BITS + CNT_W;
	localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int LCMP_W = (CNT_W > EXT_IDX_W) ? CNT_W : EXT_IDX_W;
	localparam int BIT_W = $clog2(RND_W);
	localparam logic [WEIGHT_BITS-1:0] WMAX = {WEIGHT_BITS{1'b1}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_UPD,
		ST_FIN
	} state_t;

	state_t                 state_q;
	logic [CFG_W-1:0]       active_count_q;
	logic [NUM_ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]       n_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [BIT_W-1:0]       bit_q;
	logic [SUM_W-1:0]       acc_q;
	logic [SUM_W-1:0]       div_q;
	logic [SUM_W-1:0]       rem_q;
	logic [RND_W-1:0]       rnd_q;
	logic [IDX_W-1:0]       win_q;
	logic                   uniform_q;
	logic                   found_q;
	logic                   rvld_s1;
	logic                   out_valid_q;
	logic [EXT_IDX_W-1:0]   chosen_q;
	logic                   was_uniform_q;

	logic                   accept;
	logic                   cfg_wr;
	logic                   load_ok;
	logic [CNT_W-1:0]       n_eff;
	logic [IDX_W-1:0]       raddr;
	logic [IDX_W-1:0]       prev_idx;
	logic [WEIGHT_BITS-1:0] rdata;
	logic [WEIGHT_BITS-1:0] w_rd;
	logic [WEIGHT_BITS-1:0] w_aged;
	logic [SUM_W-1:0]       acc_sum;
	logic [SUM_W:0]         rem_sh;
	logic [SUM_W-1:0]       rem_next;
	logic                   hit;
	logic                   we;
	logic [IDX_W-1:0]       waddr;
	logic [WEIGHT_BITS-1:0] wdata;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == REG_ACTIVE_COUNT) ?
		{{(APB_DATA_W-CFG_W){1'b0}}, active_count_q} : '0;

	assign out_valid    = out_valid_q;
	assign chosen_index = chosen_q;
	assign was_uniform  = was_uniform_q;

	always_comb begin
		if (active_count_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (CMP_W'(active_count_q) > CMP_W'(NUM_ENTRIES)) begin
			n_eff = CNT_W'(NUM_ENTRIES);
		end else begin
			n_eff = CNT_W'(active_count_q);
		end
	end

	assign load_ok = LCMP_W'(load_index) < LCMP_W'(NUM_ENTRIES);

	// shared datapath: accumulate, divide step, aging
	assign raddr    = cnt_q[IDX_W-1:0];
	assign prev_idx = IDX_W'(cnt_q - CNT_W'(1));
	assign w_rd     = rvld_s1 ? rdata : '0;
	assign acc_sum  = acc_q + SUM_W'(w_rd);
	assign w_aged   = (w_rd == WMAX) ? w_rd : w_rd + WEIGHT_BITS'(1);
	assign rem_sh   = {rem_q, rnd_q[RND_W-1]};
	assign rem_next = (rem_sh >= {1'b0, div_q}) ? SUM_W'(rem_sh - {1'b0, div_q})
		: rem_sh[SUM_W-1:0];
	assign hit      = !found_q && (uniform_q ? (prev_idx == IDX_W'(rem_q))
		: (rem_q < acc_sum));

	always_comb begin
		we    = 1'b0;
		waddr = prev_idx;
		wdata = hit ? '0 : w_aged;
		if (accept && mode == MODE_LOAD) begin
			we    = load_ok;
			waddr = IDX_W'(load_index);
			wdata = WEIGHT_BITS'(load_weight);
		end else if (accept && n_eff == CNT_W'(1)) begin
			we    = 1'b1;
			waddr = '0;
			wdata = '0;
		end else if (state_q == ST_UPD && cnt_q != '0) begin
			we = 1'b1;
		end
	end

	wrsa_ram #(
		.WIDTH(WEIGHT_BITS),
		.DEPTH(NUM_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_count_q <= CFG_W'(16);
		end else if (cfg_wr && paddr[2] == REG_ACTIVE_COUNT) begin
			active_count_q <= pwdata[CFG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rvld_s1 <= valid_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			out_valid_q   <= 1'b0;
			n_q           <= '0;
			cnt_q         <= '0;
			bit_q         <= '0;
			found_q       <= 1'b0;
			uniform_q     <= 1'b0;
			win_q         <= '0;
			acc_q         <= '0;
			div_q         <= '0;
			rem_q         <= '0;
			rnd_q         <= '0;
			chosen_q      <= '0;
			was_uniform_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && mode == MODE_SELECT) begin
						n_q   <= n_eff;
						rnd_q <= random_word;
						cnt_q <= '0;
						acc_q <= '0;
						if (n_eff == CNT_W'(1)) begin
							win_q     <= '0;
							uniform_q <= 1'b0;
							state_q   <= ST_FIN;
						end else begin
							state_q <= ST_SUM;
						end
					end
				end
				ST_SUM: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q != '0) begin
						acc_q <= acc_sum;
					end
					if (cnt_q == n_q) begin
						uniform_q <= (acc_sum == '0);
						div_q     <= (acc_sum == '0) ? SUM_W'(n_q) : acc_sum;
						rem_q     <= '0;
						bit_q     <= '0;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= rem_next;
					rnd_q <= rnd_q << 1;
					bit_q <= bit_q + BIT_W'(1);
					if (bit_q == BIT_W'(RND_W - 1)) begin
						cnt_q   <= '0;
						acc_q   <= '0;
						found_q <= 1'b0;
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q != '0) begin
						acc_q <= acc_sum;
						if (hit) begin
							found_q <= 1'b1;
							win_q   <= prev_idx;
						end
					end
					if (cnt_q == n_q) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q   <= 1'b1;
						chosen_q      <= EXT_IDX_W'(win_q);
						was_uniform_q <= uniform_q;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < div_q)
		else $error("remainder not below divisor");

	a_winner_found: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPD && cnt_q == n_q |-> found_q || hit)
		else $error("walk ended without a winner");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && mode == MODE_LOAD && !out_valid_q |=> !out_valid_q)
		else $error("load item produced a result item");

	a_winner_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |-> CNT_W'(win_q) < n_q)
		else $error("winner outside active entries");

endmodule

// ----- sim/testbench.sv -----
// testbench for weighted_random_select_aging: random and directed items checked against a predictor
module testbench;
	import wrsa_pkg::*;

	localparam int NUM_ENTRIES = 16;
	localparam int WEIGHT_BITS = 16;
	localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = '1;
	localparam logic [APB_ADDR_W-1:0] ACTIVE_COUNT_ADDR = APB_ADDR_W'(4 * REG_ACTIVE_COUNT);
	localparam int SETTLE_CYCLES = 2 * NUM_ENTRIES + 64;

	typedef struct packed {
		logic                 mode;
		logic [RND_W-1:0]     rnd;
		logic [EXT_IDX_W-1:0] idx;
		logic [LOAD_W-1:0]    weight;
	} weight_req_t;

	typedef struct packed {
		logic [EXT_IDX_W-1:0] idx;
		logic                 uniform;
	} pick_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  mode = MODE_SELECT;
	logic [RND_W-1:0]      random_word = '0;
	logic [EXT_IDX_W-1:0]  load_index = '0;
	logic [LOAD_W-1:0]     load_weight = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [EXT_IDX_W-1:0]  chosen_index;
	logic                  was_uniform;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	logic [WEIGHT_BITS-1:0] weight_copy [NUM_ENTRIES];
	logic [CFG_W-1:0]       active_cnt = CFG_W'(16);
	weight_req_t            req_queue [$];
	pick_t                  expected_picks [$];
	weight_req_t            next_req;
	pick_t                  drv_pick;
	pick_t                  seen_pick;
	bit                     quiet = 1'b0;
	int                     gap_left = 0;
	int                     stall_left = 0;
	int                     errors = 0;
	int                     loads_done = 0;
	int                     selects_done = 0;
	int                     uniform_seen = 0;
	int                     single_seen = 0;
	int                     settings_used = 1;

	weighted_random_select_aging #(
		.NUM_ENTRIES(NUM_ENTRIES),
		.WEIGHT_BITS(WEIGHT_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.random_word(random_word),
		.load_index(load_index),
		.load_weight(load_weight),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.chosen_index(chosen_index),
		.was_uniform(was_uniform),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		errors++;
		$display("ERROR at %0t: %s", $time, msg);
	endtask

	function automatic int live_entries();
		if (active_cnt == 0)
			return 1;
		if (active_cnt > NUM_ENTRIES)
			return NUM_ENTRIES;
		return int'(active_cnt);
	endfunction

	// winner of one select, then aging and clearing of the weight copy
	function automatic pick_t pick_winner(input logic [RND_W-1:0] rnd);
		int unsigned n;
		int unsigned total;
		int unsigned r;
		int unsigned run;
		bit found;
		pick_t p;
		n = live_entries();
		p = '0;
		if (n == 1) begin
			weight_copy[0] = '0;
			return p;
		end
		total = 0;
		for (int i = 0; i < n; i++)
			total += weight_copy[i];
		if (total == 0) begin
			p.idx = EXT_IDX_W'(rnd % n);
			p.uniform = 1'b1;
		end else begin
			r = rnd % total;
			run = 0;
			found = 0;
			for (int i = 0; i < n; i++) begin
				run += weight_copy[i];
				if (!found && r < run) begin
					p.idx = EXT_IDX_W'(i);
					found = 1;
				end
			end
		end
		for (int i = 0; i < n; i++)
			if (weight_copy[i] != WEIGHT_MAX)
				weight_copy[i] = weight_copy[i] + 1'b1;
		weight_copy[p.idx] = '0;
		return p;
	endfunction

	function automatic int pick_idle(input int zero_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < zero_pct)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		if (r < 98)
			return $urandom_range(5, 12);
		return $urandom_range(20, 60);
	endfunction

	// item driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				if (mode == MODE_LOAD) begin
					weight_copy[load_index] = load_weight[WEIGHT_BITS-1:0];
					loads_done++;
				end else begin
					if (live_entries() == 1)
						single_seen++;
					drv_pick = pick_winner(random_word);
					if (drv_pick.uniform)
						uniform_seen++;
					expected_picks.push_back(drv_pick);
					selects_done++;
				end
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (req_queue.size() > 0) begin
					next_req = req_queue.pop_front();
					mode <= next_req.mode;
					random_word <= next_req.rnd;
					load_index <= next_req.idx;
					load_weight <= next_req.weight;
					in_valid <= 1'b1;
					gap_left = quiet ? 0 : pick_idle(60);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			stall_left = quiet ? 0 : pick_idle(85);
			out_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_picks.size() == 0) begin
				report_mismatch($sformatf("unexpected result index %0d", chosen_index));
			end else begin
				seen_pick = expected_picks.pop_front();
				if (chosen_index !== seen_pick.idx)
					report_mismatch($sformatf("chosen_index %0d, predicted %0d",
						chosen_index, seen_pick.idx));
				if (was_uniform !== seen_pick.uniform)
					report_mismatch($sformatf("was_uniform %0b, predicted %0b",
						was_uniform, seen_pick.uniform));
			end
		end
	end

	task automatic add_load(input int idx, input logic [LOAD_W-1:0] w);
		weight_req_t r;
		r = '0;
		r.mode = MODE_LOAD;
		r.idx = EXT_IDX_W'(idx);
		r.weight = w;
		r.rnd = $urandom;
		req_queue.push_back(r);
	endtask

	task automatic add_select(input logic [RND_W-1:0] rnd);
		weight_req_t r;
		r.mode = MODE_SELECT;
		r.rnd = rnd;
		r.idx = EXT_IDX_W'($urandom);
		r.weight = LOAD_W'($urandom);
		req_queue.push_back(r);
	endtask

	function automatic logic [LOAD_W-1:0] rand_weight();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return LOAD_W'($urandom_range(0, 3));
		if (r < 55)
			return LOAD_W'($urandom_range(16'hFFF0, 16'hFFFF));
		return LOAD_W'($urandom);
	endfunction

	function automatic logic [RND_W-1:0] rand_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return RND_W'($urandom_range(0, 64));
		if (r < 20)
			return ~RND_W'($urandom_range(0, 255));
		return $urandom;
	endfunction

	task automatic fill_random(input int count);
		int added;
		int r;
		int k;
		added = 0;
		while (added < count) begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				add_select(rand_word());
				added++;
			end else if (r < 70) begin
				add_load($urandom_range(0, NUM_ENTRIES - 1), rand_weight());
				added++;
			end else if (r < 78) begin
				// wipe every weight so the next pick goes uniform unless only one entry is active
				for (int i = 0; i < NUM_ENTRIES; i++)
					add_load(i, '0);
				k = $urandom_range(1, 2);
				for (int i = 0; i < k; i++)
					add_select(rand_word());
				added += NUM_ENTRIES + k;
			end else if (r < 88) begin
				for (int i = 0; i < 4; i++)
					add_load($urandom_range(0, NUM_ENTRIES - 1), WEIGHT_MAX);
				add_select(rand_word());
				add_select(rand_word());
				added += 6;
			end else begin
				for (int i = 0; i < NUM_ENTRIES; i++)
					add_load(i, rand_weight());
				add_select(rand_word());
				added += NUM_ENTRIES + 1;
			end
		end
	endtask

	task automatic wait_idle();
		while (req_queue.size() != 0 || in_valid || expected_picks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_active_count(input logic [CFG_W-1:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ACTIVE_COUNT_ADDR;
		pwdata <= APB_DATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		active_cnt = v;
		settings_used++;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== APB_DATA_W'(v))
			report_mismatch($sformatf("active_count reads %0d, wrote %0d", prdata, v));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		logic [CFG_W-1:0] cfg_plan [9];
		cfg_plan = '{16, 2, 1, 0, 31, 8, 16, 3, 17};
		for (int i = 0; i < NUM_ENTRIES; i++)
			weight_copy[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all zero after reset, then aging, extremes of weight and word, saturation
		add_select('0);
		add_select('1);
		add_load(15, '1);
		add_load(0, '0);
		add_select('1);
		add_select('0);
		add_load(1, '1);
		add_load(2, '1);
		add_load(3, '1);
		add_select(32'd5);
		add_select('0);
		wait_idle();

		// single active entry
		set_active_count(CFG_W'(1));
		add_select(32'd123);
		add_load(0, '1);
		add_select(32'd7);
		wait_idle();

		// zero count acts as one
		set_active_count(CFG_W'(0));
		add_load(0, 16'd5);
		add_select('1);
		wait_idle();

		// counts above the entry total saturate
		set_active_count(CFG_W'(31));
		add_select('1);
		add_select(32'h8000_0000);
		wait_idle();
		set_active_count(CFG_W'(17));
		add_select(32'h1234_5678);
		wait_idle();

		set_active_count(CFG_W'(2));
		add_load(0, '0);
		add_load(1, '0);
		add_select('1);
		wait_idle();

		for (int ph = 0; ph < 9; ph++) begin
			if (ph == 6)
				set_active_count(CFG_W'($urandom_range(0, 31)));
			else
				set_active_count(cfg_plan[ph]);
			quiet = (ph == 3 || ph == 7);
			fill_random(160);
			wait_idle();
		end

		if (expected_picks.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_picks.size()));
		$display("covered %0d selects (%0d uniform, %0d single-entry) and %0d weight loads",
			selects_done, uniform_seen, single_seen, loads_done);
		$display("over %0d active-count settings with random sender gaps and result stalls",
			settings_used);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
